// ===== rtl/core/wfqs_pkg.sv =====
// ----------------------------------------------------------------------------
// wfqs_pkg
// Shared types and constants of the weighted fair queue selector.
// ----------------------------------------------------------------------------
package wfqs_pkg;

  localparam int unsigned MaxQueues = 8;
  localparam int unsigned QidW      = 3;
  localparam int unsigned WeightW   = 8;
  localparam int unsigned CountW    = 40;
  localparam int unsigned BytesW    = 16;
  localparam int unsigned ProdW     = CountW + WeightW;
  localparam int unsigned ApbAddrW  = 5;
  localparam int unsigned ApbDataW  = 32;

  localparam logic [CountW-1:0] CountMax = '1;

  // Request type codes.
  localparam logic ReqSelect  = 1'b0;
  localparam logic ReqAccount = 1'b1;

  typedef logic [WeightW-1:0] weight_t;
  typedef weight_t [MaxQueues-1:0] weight_arr_t;

  // Access to the counter memory from the controller.
  typedef struct packed {
    logic              rd_en;
    logic [QidW-1:0]   rd_addr;
    logic              wr_en;
    logic [QidW-1:0]   wr_addr;
    logic [CountW-1:0] wr_data;
  } mem_req_t;

  // A weight register that holds zero acts as weight one.
  function automatic weight_t eff_weight(input weight_t w);
    return (w == '0) ? weight_t'(1) : w;
  endfunction

endpackage

// ===== rtl/core/wfqs_cnt_mem.sv =====
// ----------------------------------------------------------------------------
// wfqs_cnt_mem
// Byte counter memory: one write and one registered read per cycle, with a
// valid flag per entry so that entries never written since reset read zero.
// ----------------------------------------------------------------------------
module wfqs_cnt_mem #(
  parameter int unsigned NumQueues = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  wfqs_pkg::mem_req_t        req_i,
  output logic [wfqs_pkg::CountW-1:0] rd_data_o
);
  import wfqs_pkg::*;

  localparam int unsigned IdxW = (NumQueues > 1) ? $clog2(NumQueues) : 1;

  logic [CountW-1:0]    mem_q [NumQueues];
  logic [NumQueues-1:0] valid_q;
  logic [CountW-1:0]    rd_data_q;
  logic                 rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr[IdxW-1:0]] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr[IdxW-1:0]];
      rd_vld_q  <= valid_q[req_i.rd_addr[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.wr_en) begin
      valid_q[req_i.wr_addr[IdxW-1:0]] <= 1'b1;
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== rtl/core/wfqs_cfg.sv =====
// ----------------------------------------------------------------------------
// wfqs_cfg
// APB register file holding the eight queue weights.
// ----------------------------------------------------------------------------
module wfqs_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wfqs_pkg::ApbAddrW-1:0] paddr,
  input  logic [wfqs_pkg::ApbDataW-1:0] pwdata,
  output logic [wfqs_pkg::ApbDataW-1:0] prdata,
  output logic                          pready,
  output wfqs_pkg::weight_arr_t         weights_o
);
  import wfqs_pkg::*;

  weight_arr_t      weight_q;
  logic [QidW-1:0]  reg_idx;

  assign reg_idx = paddr[ApbAddrW-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxQueues; i++) begin
        weight_q[i] <= weight_t'(1);
      end
    end else if (psel && penable && pwrite) begin
      weight_q[reg_idx] <= pwdata[WeightW-1:0];
    end
  end

  assign prdata    = ApbDataW'(weight_q[reg_idx]);
  assign weights_o = weight_q;

endmodule

// ===== rtl/core/wfqs_ctrl.sv =====
// ----------------------------------------------------------------------------
// wfqs_ctrl
// Request sequencer: read-modify-write of one counter for an account item,
// and a walk over all counters with a cross-multiply compare for a select.
// ----------------------------------------------------------------------------
module wfqs_ctrl #(
  parameter int unsigned NumQueues = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          req_type_i,
  input  logic [wfqs_pkg::MaxQueues-1:0] backlog_mask_i,
  input  logic [wfqs_pkg::QidW-1:0]     queue_id_i,
  input  logic [wfqs_pkg::BytesW-1:0]   byte_count_i,
  input  wfqs_pkg::weight_arr_t         weights_i,
  input  logic [wfqs_pkg::CountW-1:0]   rd_data_i,
  output wfqs_pkg::mem_req_t            mem_req_o,
  output logic                          busy_o,
  output logic                          done_o,
  output logic                          grant_valid_o,
  output logic [wfqs_pkg::QidW-1:0]     grant_queue_o
);
  import wfqs_pkg::*;

  localparam int unsigned IdxW = (NumQueues > 1) ? $clog2(NumQueues) : 1;

  typedef enum logic [1:0] {
    StIdle,
    StAcc,
    StSel
  } state_e;

  state_e              state_q;
  logic [IdxW-1:0]     idx_q;
  logic [QidW-1:0]     qid_q;
  logic [BytesW-1:0]   bytes_q;
  logic [MaxQueues-1:0] mask_q;
  logic                found_q;
  logic [QidW-1:0]     best_q;
  logic [CountW-1:0]   best_cnt_q;
  weight_t             best_w_q;
  logic                done_q;
  logic                grant_valid_q;
  logic [QidW-1:0]     grant_queue_q;

  logic [QidW-1:0]     idx_ext;
  logic                last;
  weight_t             w_cur;
  logic [ProdW-1:0]    lhs;
  logic [ProdW-1:0]    rhs;
  logic                take;
  logic [CountW:0]     sum;
  logic [CountW-1:0]   sat_sum;
  logic                qid_ok;

  assign idx_ext = QidW'(idx_q);
  assign last    = (idx_q == IdxW'(NumQueues - 1));
  assign w_cur   = eff_weight(weights_i[idx_ext]);

  // Exact ratio compare: cnt_i / w_i < best / w_best.
  assign lhs  = ProdW'(rd_data_i) * ProdW'(best_w_q);
  assign rhs  = ProdW'(best_cnt_q) * ProdW'(w_cur);
  assign take = mask_q[idx_ext] && (!found_q || (lhs < rhs));

  assign sum     = {1'b0, rd_data_i} + (CountW + 1)'(bytes_q);
  assign sat_sum = sum[CountW] ? CountMax : sum[CountW-1:0];

  assign qid_ok = ({1'b0, queue_id_i} < (QidW + 1)'(NumQueues));

  always_comb begin
    mem_req_o = '0;
    unique case (state_q)
      StIdle: begin
        mem_req_o.rd_en   = start_i;
        mem_req_o.rd_addr = (req_type_i == ReqAccount) ? queue_id_i : '0;
      end
      StAcc: begin
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = qid_q;
        mem_req_o.wr_data = sat_sum;
      end
      StSel: begin
        // Fetch the next counter while the current one is compared.
        mem_req_o.rd_en   = !last;
        mem_req_o.rd_addr = idx_ext + QidW'(1);
      end
      default: begin
        mem_req_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      done_q        <= 1'b0;
      found_q       <= 1'b0;
      grant_valid_q <= 1'b0;
      grant_queue_q <= '0;
      idx_q         <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (start_i) begin
            if (req_type_i == ReqAccount) begin
              qid_q   <= queue_id_i;
              bytes_q <= byte_count_i;
              if (qid_ok) begin
                state_q <= StAcc;
              end
            end else begin
              mask_q  <= backlog_mask_i;
              idx_q   <= '0;
              found_q <= 1'b0;
              state_q <= StSel;
            end
          end
        end
        StAcc: begin
          state_q <= StIdle;
        end
        StSel: begin
          if (take) begin
            found_q    <= 1'b1;
            best_q     <= idx_ext;
            best_cnt_q <= rd_data_i;
            best_w_q   <= w_cur;
          end
          if (last) begin
            done_q        <= 1'b1;
            grant_valid_q <= found_q || take;
            if (take) begin
              grant_queue_q <= idx_ext;
            end else if (found_q) begin
              grant_queue_q <= best_q;
            end else begin
              grant_queue_q <= '0;
            end
            state_q <= StIdle;
          end else begin
            idx_q <= idx_q + IdxW'(1);
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign busy_o        = (state_q != StIdle);
  assign done_o        = done_q;
  assign grant_valid_o = grant_valid_q;
  assign grant_queue_o = grant_queue_q;

endmodule

// ===== rtl/core/weighted_fair_queue_selector_core.sv =====
// Select item: busy after acceptance while all counters are walked, one
// counter read and compared per cycle through the single memory read port;
// done_o strobes in the first cycle with busy low. Account item: busy after
// acceptance for the read, then the write back, if the queue id is in range.
// Results cannot be held off. Reset clears all counters to zero (per-entry
// valid flags) and sets weights to 1.
// ----------------------------------------------------------------------------
// weighted_fair_queue_selector_core
// Grants the backlogged queue with the smallest bytes-sent to weight ratio
// and keeps saturating per-queue byte counters.
// ----------------------------------------------------------------------------
module weighted_fair_queue_selector_core #(
  parameter int unsigned NUM_QUEUES = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wfqs_pkg::ApbAddrW-1:0] paddr,
  input  logic [wfqs_pkg::ApbDataW-1:0] pwdata,
  output logic [wfqs_pkg::ApbDataW-1:0] prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  logic                          req_type_i,
  input  logic [7:0]                    backlog_mask_i,
  input  logic [2:0]                    queue_id_i,
  input  logic [15:0]                   byte_count_i,
  output logic                          done_o,
  output logic                          grant_valid_o,
  output logic [2:0]                    grant_queue_o
);
  import wfqs_pkg::*;

  weight_arr_t       weights;
  mem_req_t          mem_req;
  logic [CountW-1:0] rd_data;

  wfqs_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .weights_o(weights)
  );

  wfqs_cnt_mem #(
    .NumQueues(NUM_QUEUES)
  ) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mem_req),
    .rd_data_o(rd_data)
  );

  wfqs_ctrl #(
    .NumQueues(NUM_QUEUES)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .req_type_i    (req_type_i),
    .backlog_mask_i(backlog_mask_i),
    .queue_id_i    (queue_id_i),
    .byte_count_i  (byte_count_i),
    .weights_i     (weights),
    .rd_data_i     (rd_data),
    .mem_req_o     (mem_req),
    .busy_o        (busy),
    .done_o        (done_o),
    .grant_valid_o (grant_valid_o),
    .grant_queue_o (grant_queue_o)
  );

endmodule

// ===== rtl/core/wfqs_chk.sv =====
// ----------------------------------------------------------------------------
// wfqs_chk
// Port-level checks of the selector's request and result timing and of its grants.
// ----------------------------------------------------------------------------
module wfqs_chk #(
  parameter int unsigned NUM_QUEUES = 8
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       req_type_i,
  input logic       done_o,
  input logic       grant_valid_o,
  input logic [2:0] grant_queue_o
);
  import wfqs_pkg::*;

  // A select item always occupies the block.
  a_select_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (req_type_i == ReqSelect) |=> busy)
    else $error("select item did not raise busy");

  // A result only ends a busy period and leaves the block free.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy) && !busy)
    else $error("result strobe outside a select walk");

  a_no_grant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !grant_valid_o |-> grant_queue_o == 3'd0)
    else $error("empty grant with nonzero queue");

  a_grant_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && grant_valid_o |-> ({1'b0, grant_queue_o} < 4'(NUM_QUEUES)))
    else $error("granted queue out of range");

endmodule

bind weighted_fair_queue_selector_core wfqs_chk #(
  .NUM_QUEUES(NUM_QUEUES)
) u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .req_type_i   (req_type_i),
  .done_o       (done_o),
  .grant_valid_o(grant_valid_o),
  .grant_queue_o(grant_queue_o)
);
